FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg
// types and constants for the flip maneuver sequencer
// ----------------------------------------------------------------------------
package fms_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SET     = 3'd1,
        PH_UP      = 3'd2,
        PH_SLOW    = 3'd3,
        PH_SPIN    = 3'd4,
        PH_DONE    = 3'd5,
        PH_RECOVER = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    localparam logic [2:0] DIR_CENTER = 3'd0;
    localparam logic [2:0] DIR_FWD    = 3'd1;
    localparam logic [2:0] DIR_BACK   = 3'd2;
    localparam logic [2:0] DIR_LEFT   = 3'd3;
    localparam logic [2:0] DIR_RIGHT  = 3'd4;

    localparam logic [2:0] REG_THRUST_BASE  = 3'd0;
    localparam logic [2:0] REG_CLIMB_TARGET = 3'd1;
    localparam logic [2:0] REG_MIN_LIFT     = 3'd2;
    localparam logic [2:0] REG_SPEED_UP_LIM = 3'd3;
    localparam logic [2:0] REG_SPIN_LIM     = 3'd4;
    localparam logic [2:0] REG_RECOVER      = 3'd5;
    localparam logic [2:0] REG_PEAK_RATE    = 3'd6;
    localparam logic [2:0] REG_RATE_STEP    = 3'd7;

    localparam int EXIT_DELAY_TICKS_DEF = 500;
    localparam int TICK_RATE_HZ_DEF     = 500;

    localparam logic        CMD_TICK   = 1'b0;
    localparam logic        CMD_SETDIR = 1'b1;
    localparam logic [27:0] ANGLE_MAX  = 28'hFFFFFFF;
    localparam int          LOW_CLIMB  = -5120;

    localparam int IN_W  = 91;
    localparam int OUT_W = 84;
endpackage

FILE: hw/rtl/flip_maneuver_sequencer.sv
// ----------------------------------------------------------------------------
// flip_maneuver_sequencer
// flip phase sequencer with stream ports and an apb register port
// ----------------------------------------------------------------------------
// one transaction in gives one transaction out. an accepted item lands in an
// input register, then combinational logic updates the flip state and builds
// the result, which sits in an output register. while a result waits on a
// stalled sink the input register holds the next item and tready drops until
// the result is taken, so with a taking sink an item can be accepted on every
// clock and the sustained rate is one item per cycle. the spin angle scale
// follows TICK_RATE_HZ and the exit delay follows EXIT_DELAY_TICKS. the user
// writes registers at byte address 4*i only while no transaction is in
// flight; the block itself does not enforce this.
module flip_maneuver_sequencer
    import fms_pkg::*;
#(
    parameter int EXIT_DELAY_TICKS = EXIT_DELAY_TICKS_DEF,
    parameter int TICK_RATE_HZ     = TICK_RATE_HZ_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // command[0], direction[3:1], thrust_in[19:4], climb_speed[38:20],
    // roll_in[55:39], pitch_in[72:56], yaw_in[89:73], key_flight[90], zero pad
    input  logic [95:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // phase[2:0], thrust_out[18:3], thrust_drive[19], altitude_hold_off[20],
    // altitude_absolute[21], attitude_drive[22], pitch_out[42:23],
    // roll_out[62:43], yaw_out[79:63], flip_direction_out[82:80],
    // flip_exited[83], zero pad
    output logic [87:0] o_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [27:0] HALF_TURN = 28'(180 * TICK_RATE_HZ * 256);
    localparam logic [27:0] FULL_TURN = 28'(2 * 180 * TICK_RATE_HZ * 256);
    localparam int          ED_W      = $clog2(EXIT_DELAY_TICKS + 1);

    // configuration registers
    logic [15:0] r_tb, r_minlift, r_rstep;
    logic [17:0] r_climb_tgt;
    logic [11:0] r_uplim, r_spinlim;
    logic [9:0]  r_rec_ticks;
    logic [18:0] r_peak;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tb        <= 16'd32000;
            r_climb_tgt <= 18'd26880;
            r_minlift   <= 16'd28000;
            r_uplim     <= 12'd400;
            r_spinlim   <= 12'd800;
            r_rec_ticks <= 10'd160;
            r_peak      <= 19'd353280;
            r_rstep     <= 16'd5565;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_THRUST_BASE:  r_tb        <= pwdata[15:0];
                REG_CLIMB_TARGET: r_climb_tgt <= pwdata[17:0];
                REG_MIN_LIFT:     r_minlift   <= pwdata[15:0];
                REG_SPEED_UP_LIM: r_uplim     <= pwdata[11:0];
                REG_SPIN_LIM:     r_spinlim   <= pwdata[11:0];
                REG_RECOVER:      r_rec_ticks <= pwdata[9:0];
                REG_PEAK_RATE:    r_peak      <= pwdata[18:0];
                REG_RATE_STEP:    r_rstep     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_THRUST_BASE:  prdata = {16'd0, r_tb};
            REG_CLIMB_TARGET: prdata = {14'd0, r_climb_tgt};
            REG_MIN_LIFT:     prdata = {16'd0, r_minlift};
            REG_SPEED_UP_LIM: prdata = {20'd0, r_uplim};
            REG_SPIN_LIM:     prdata = {20'd0, r_spinlim};
            REG_RECOVER:      prdata = {22'd0, r_rec_ticks};
            REG_PEAK_RATE:    prdata = {13'd0, r_peak};
            REG_RATE_STEP:    prdata = {16'd0, r_rstep};
            default:          prdata = 32'd0;
        endcase
    end

    // pipeline: input register (item) -> output register (result)
    logic              r_iv, r_ov;
    logic [IN_W-1:0]   r_item;
    logic [OUT_W-1:0]  r_res;
    logic              adv, take_in;

    // item moves forward when the output slot is free or being drained
    assign adv        = r_iv && (!r_ov || i_m_tready);
    assign o_s_tready = !r_iv || adv;
    assign take_in    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {4'd0, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (take_in)      r_iv <= 1'b1;
            else if (adv)     r_iv <= 1'b0;
            if (adv)          r_ov <= 1'b1;
            else if (i_m_tready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) r_item <= i_s_tdata[IN_W-1:0];
    end

    // item fields
    logic               f_cmd, f_key;
    logic [2:0]         f_dir;
    logic [15:0]        f_thr;
    logic signed [18:0] f_climb;
    logic signed [16:0] f_roll, f_pitch, f_yaw;

    assign f_cmd   = r_item[0];
    assign f_dir   = r_item[3:1];
    assign f_thr   = r_item[19:4];
    assign f_climb = r_item[38:20];
    assign f_roll  = r_item[55:39];
    assign f_pitch = r_item[72:56];
    assign f_yaw   = r_item[89:73];
    assign f_key   = r_item[90];

    // flip state; the timeout counter runs one past a 12-bit limit
    t_phase             r_phase, n_phase;
    logic [2:0]         r_fdir, n_fdir, r_cdir, n_cdir;
    logic [ED_W-1:0]    r_edelay, n_edelay;
    logic               r_exited, n_exited;
    logic [15:0]        r_base, n_base, r_ramp, n_ramp, r_maxt, n_maxt;
    logic [23:0]        r_inc, n_inc;
    logic [12:0]        r_tmo, n_tmo;
    logic [9:0]         r_rec, n_rec;
    logic [19:0]        r_rate, n_rate;
    logic [27:0]        r_angle, n_angle;
    logic [15:0]        r_dwell, n_dwell;
    logic signed [16:0] r_hr, r_hp, r_hy, n_hr, n_hp, n_hy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_fdir   <= DIR_CENTER;
            r_cdir   <= DIR_CENTER;
            r_edelay <= '0;
            r_exited <= 1'b1;
            r_base   <= '0; r_ramp <= '0; r_maxt <= '0; r_inc <= '0;
            r_tmo    <= '0; r_rec  <= '0; r_rate <= '0; r_angle <= '0;
            r_dwell  <= '0; r_hr   <= '0; r_hp   <= '0; r_hy    <= '0;
        end else if (adv) begin
            r_phase  <= n_phase;  r_fdir <= n_fdir; r_cdir <= n_cdir;
            r_edelay <= n_edelay; r_exited <= n_exited;
            r_base   <= n_base;   r_ramp <= n_ramp; r_maxt <= n_maxt; r_inc <= n_inc;
            r_tmo    <= n_tmo;    r_rec  <= n_rec;  r_rate <= n_rate; r_angle <= n_angle;
            r_dwell  <= n_dwell;  r_hr   <= n_hr;   r_hp   <= n_hp;   r_hy <= n_hy;
        end
    end

    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        if (v < 0)          return 16'd0;
        else if (v > 65535) return 16'hFFFF;
        else                return v[15:0];
    endfunction

    function automatic logic [19:0] sat20(input logic signed [21:0] v);
        if (v > 22'sd524287)       return 20'h7FFFF;
        else if (v < -22'sd524288) return 20'h80000;
        else                       return v[19:0];
    endfunction

    // floor(x/10) by reciprocal multiply, exact for x below 2^22
    function automatic logic [19:0] div10(input logic [22:0] x);
        logic [43:0] p;
        p = 44'(x) * 44'd838861;
        return p[42:23];
    endfunction

    // set-phase derived levels; tb*256/90 by reciprocal multiply with correction
    logic [31:0] set_v;
    logic [15:0] set_base;
    logic [23:0] tb256;
    logic [43:0] q_prod;
    logic [23:0] q_est, q_rem;
    logic [23:0] set_inc;
    logic [16:0] set_max;

    always_comb begin
        set_v = 32'(r_tb) * 32'd12;
        if (set_v <= 32'd90000) set_base = 16'd0;
        else                    set_base = sat16(32'(div10(23'(set_v - 32'd90000))));
        tb256   = {r_tb, 8'd0};
        // 2^24/90 rounded down; estimate is exact or one low
        q_prod  = 44'(tb256) * 44'd186413;
        q_est   = 24'(q_prod[41:24]);
        q_rem   = tb256 - 24'(q_est * 24'd90);
        set_inc = (q_rem >= 24'd90) ? q_est + 24'd1 : q_est;
        set_max = 17'(r_tb) + 17'd20000;
        if (set_max > 17'd62000) set_max = 17'd62000;
    end

    // slow-down step: trunc((ramp*10 - 65000 + base)/10), clamped to 0..65535
    logic signed [31:0] slow_v;
    logic [15:0]        slow_ramp;
    always_comb begin
        slow_v = 32'(r_ramp) * 32'sd10 - 32'sd65000 + 32'(r_base);
        if (slow_v < 0) slow_ramp = 16'd0;
        else            slow_ramp = sat16(32'(div10(23'(slow_v))));
    end

    logic [31:0] rise1, rise2;
    assign rise1 = 32'(r_ramp) + 32'(r_inc[23:8]);
    assign rise2 = 32'(r_ramp) + 32'({r_inc, 1'b0} >> 8);

    // result fields
    logic [15:0]        o_thr;
    logic               o_tdrv, o_hold, o_abs, o_adrv;
    logic [19:0]        o_pitch, o_roll;
    logic [16:0]        o_yaw;

    // spin step terms
    logic               spin;
    logic [12:0]        spin_tmo;
    logic               spin_err;
    logic [28:0]        ang_sum;
    logic [27:0]        ang_new;
    logic signed [31:0] spin_thr_v;
    logic signed [20:0] rate_s;

    always_comb begin
        n_phase = r_phase; n_fdir = r_fdir; n_cdir = r_cdir;
        n_edelay = r_edelay; n_exited = r_exited;
        n_base = r_base; n_ramp = r_ramp; n_maxt = r_maxt; n_inc = r_inc;
        n_tmo = r_tmo; n_rec = r_rec; n_rate = r_rate; n_angle = r_angle;
        n_dwell = r_dwell; n_hr = r_hr; n_hp = r_hp; n_hy = r_hy;
        o_thr = '0; o_tdrv = 1'b0; o_hold = 1'b0; o_abs = 1'b0; o_adrv = 1'b0;
        o_pitch = '0; o_roll = '0; o_yaw = '0;
        spin = 1'b0;
        spin_tmo = '0; spin_err = 1'b0; ang_sum = '0; ang_new = '0;
        spin_thr_v = '0; rate_s = '0;

        if (f_cmd == CMD_SETDIR) begin
            n_fdir = f_dir;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (r_fdir != DIR_CENTER) begin
                        if (f_thr > r_minlift && 32'(f_climb) > LOW_CLIMB) begin
                            n_phase  = PH_SET;
                            n_edelay = ED_W'(EXIT_DELAY_TICKS);
                            n_exited = 1'b0;
                        end else begin
                            n_fdir = DIR_CENTER;
                        end
                    end else if (!r_exited) begin
                        if (r_edelay != '0) n_edelay = r_edelay - 1'b1;
                        else                n_exited = 1'b1;
                    end
                end
                PH_SET: begin
                    n_rate = '0; n_dwell = '0; n_angle = '0; n_tmo = '0;
                    n_cdir = r_fdir;
                    n_base = set_base;
                    n_inc  = set_inc;
                    n_maxt = set_max[15:0];
                    n_ramp = set_base;
                    n_hr = f_roll; n_hp = f_pitch; n_hy = f_yaw;
                    n_phase = PH_UP;
                end
                PH_UP: begin
                    if (f_climb < $signed({1'b0, r_climb_tgt})) begin
                        if (r_ramp < r_maxt) n_ramp = sat16(rise1);
                        o_hold = 1'b1; o_tdrv = 1'b1; o_thr = n_ramp;
                        n_tmo = r_tmo + 1'b1;
                        if (r_tmo > r_uplim) begin
                            n_tmo = '0; n_phase = PH_SLOW;
                        end
                    end else begin
                        n_tmo = '0; n_phase = PH_SLOW;
                    end
                end
                PH_SLOW: begin
                    if (r_ramp > r_base) n_ramp = slow_ramp;
                    else                 n_phase = PH_SPIN;
                    spin = 1'b1;
                end
                PH_SPIN: spin = 1'b1;
                PH_DONE: begin
                    o_hold = 1'b1; o_tdrv = 1'b1; o_thr = r_ramp;
                    n_ramp = r_base;
                    n_rec = '0; n_tmo = '0;
                    n_fdir = DIR_CENTER; n_cdir = DIR_CENTER;
                    n_phase = PH_RECOVER;
                end
                PH_RECOVER: begin
                    n_rec = r_rec + 1'b1;
                    if (r_rec < r_rec_ticks) begin
                        if (r_ramp < r_maxt) n_ramp = sat16(rise2);
                        o_hold = 1'b1; o_tdrv = 1'b1; o_thr = n_ramp;
                    end else begin
                        n_tmo = '0; n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_rec = '0;
                    n_fdir = DIR_CENTER; n_cdir = DIR_CENTER;
                    o_hold = 1'b1; o_tdrv = 1'b1; o_thr = '0;
                    n_tmo = r_tmo + 1'b1;
                    if (r_tmo > 13'd1) begin
                        n_tmo = '0;
                        if (f_key) begin
                            o_hold = 1'b0; o_abs = 1'b1;
                        end
                        n_phase = PH_IDLE;
                    end
                end
            endcase

            if (spin) begin
                spin_tmo = r_tmo + 1'b1;
                spin_err = r_tmo > r_spinlim;
                n_tmo = spin_err ? 13'd0 : spin_tmo;
                if (spin_err) n_phase = PH_ERROR;
                o_hold = 1'b1; o_tdrv = 1'b1;
                spin_thr_v = ($signed({16'd0, r_base} <<< 8)
                             - 32'sd3 * $signed({12'd0, r_rate})) >>> 8;
                o_thr = sat16(spin_thr_v);
                ang_sum = 29'(r_angle) + 29'(r_rate);
                ang_new = ang_sum[28] ? ANGLE_MAX : ang_sum[27:0];
                n_angle = ang_new;
                if (ang_new < HALF_TURN) begin
                    if (r_rate < 20'(r_peak)) n_rate = r_rate + 20'(r_rstep);
                    else if (r_dwell != 16'hFFFF) n_dwell = r_dwell + 1'b1;
                end else if (r_dwell != '0) begin
                    n_dwell = r_dwell - 1'b1;
                end else if (r_rate >= 20'(r_rstep) && ang_new < FULL_TURN) begin
                    n_rate = r_rate - 20'(r_rstep);
                end else begin
                    n_phase = PH_DONE;
                end
                if (r_cdir >= DIR_FWD && r_cdir <= DIR_RIGHT) begin
                    rate_s  = $signed({1'b0, n_rate});
                    o_adrv  = 1'b1;
                    o_pitch = 20'(r_hp); o_roll = 20'(r_hr); o_yaw = r_hy;
                    case (r_cdir)
                        DIR_FWD:  o_pitch = sat20(22'(rate_s));
                        DIR_BACK: o_pitch = sat20(-22'(rate_s));
                        DIR_LEFT: o_roll  = sat20(-22'(rate_s));
                        default:  o_roll  = sat20(22'(rate_s));
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= {n_exited, n_cdir, o_yaw, o_roll, o_pitch, o_adrv, o_abs,
                      o_hold, o_tdrv, o_thr, r_phase};
        end
    end

    `include "assert_macros.svh"

    `ASSERT_CLK(a_hold_out, i_clk, i_rst_n, (r_ov && !i_m_tready) |=> r_ov, "result dropped while stalled")
    `ASSERT_CLK(a_no_adv_empty, i_clk, i_rst_n, adv |-> r_iv, "advance without item")
    `ASSERT_CLK(a_exit_delay, i_clk, i_rst_n, (r_phase != PH_IDLE) |-> !r_exited, "exit flag set during flip")
    `ASSERT_CLK(a_cdir_idle, i_clk, i_rst_n, (r_phase == PH_IDLE) |-> (r_cdir == DIR_CENTER), "controller direction left set")

endmodule
